// File: src/four_channel_pwm_timer_unit_defines.svh
// Assertion macros shared by the PWM timer modules.
`ifndef FOUR_CHANNEL_PWM_TIMER_UNIT_DEFINES_SVH
`define FOUR_CHANNEL_PWM_TIMER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define FCPWM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fcpwm assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define FCPWM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fcpwm assertion failed");

`endif

// File: src/fcpwm_pkg.sv
// Types and constants of the four-channel PWM timer.
package fcpwm_pkg;

  localparam int PRESCALE_DIVIDE_DEF = 24;
  localparam int PERIOD_TOP_DEF      = 999;
  localparam int NUM_CH              = 4;
  localparam int CH_IDX_W            = $clog2(NUM_CH);
  localparam int DUTY_CAP            = 100;
  localparam int DUTY_IDX_W          = $clog2(DUTY_CAP + 1);
  localparam int COUNT_OUT_W         = 10;
  localparam int CFG_IDX_W           = 1;
  localparam int CFG_DATA_W          = 8;

  localparam logic [CFG_IDX_W-1:0] REG_OUT_INV      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DUTY = 1'd1;

  typedef enum logic [1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_SET_DUTY = 2'd1,
    FUNC_START    = 2'd2,
    FUNC_STOP     = 2'd3
  } func_e;

  typedef struct packed {
    func_e      func;
    logic [7:0] channel;
    logic [7:0] duty;
    logic       init_now;
  } item_t;

  typedef struct packed {
    logic                   running;
    logic [COUNT_OUT_W-1:0] count_value;
    logic [NUM_CH-1:0]      pwm_lines;
  } result_t;

endpackage

// File: src/fcpwm_core.sv
// Timer state, compare lanes and per-request update logic.
`include "four_channel_pwm_timer_unit_defines.svh"

module fcpwm_core #(
  parameter int PRESCALE_DIVIDE = fcpwm_pkg::PRESCALE_DIVIDE_DEF,
  parameter int PERIOD_TOP      = fcpwm_pkg::PERIOD_TOP_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fcpwm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fcpwm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                                push_i,
  input  fcpwm_pkg::item_t                    item_i,
  output fcpwm_pkg::result_t                  res_o
);

  localparam int PW = (PRESCALE_DIVIDE > 0) ? $clog2(PRESCALE_DIVIDE + 1) : 1;
  localparam int CW = $clog2(PERIOD_TOP + 1);
  localparam int NCH = fcpwm_pkg::NUM_CH;

  logic          out_inv_q;
  logic [7:0]    initial_duty_q;

  logic [PW-1:0] pre_q, pre_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          en_q, en_d;
  logic [CW-1:0] preload_q [NCH];
  logic [CW-1:0] preload_d [NCH];
  logic [CW-1:0] active_q  [NCH];
  logic [CW-1:0] active_d  [NCH];

  logic [CW-1:0] duty_lut [fcpwm_pkg::DUTY_CAP+1];

  logic [fcpwm_pkg::DUTY_IDX_W-1:0] init_idx, duty_idx;
  logic [fcpwm_pkg::CH_IDX_W-1:0]   ch_idx;
  logic                             ch_ok;
  logic [NCH-1:0]                   lines;

  // Percent to compare value, worked out at elaboration.
  for (genvar p = 0; p <= fcpwm_pkg::DUTY_CAP; p++) begin : g_lut
    assign duty_lut[p] = CW'((p * PERIOD_TOP) / fcpwm_pkg::DUTY_CAP);
  end

  assign init_idx = (initial_duty_q > 8'(fcpwm_pkg::DUTY_CAP)) ?
                    fcpwm_pkg::DUTY_IDX_W'(fcpwm_pkg::DUTY_CAP) :
                    initial_duty_q[fcpwm_pkg::DUTY_IDX_W-1:0];
  assign duty_idx = (item_i.duty > 8'(fcpwm_pkg::DUTY_CAP)) ?
                    fcpwm_pkg::DUTY_IDX_W'(fcpwm_pkg::DUTY_CAP) :
                    item_i.duty[fcpwm_pkg::DUTY_IDX_W-1:0];
  assign ch_ok  = (item_i.channel >= 8'd1) && (item_i.channel <= 8'(NCH));
  assign ch_idx = fcpwm_pkg::CH_IDX_W'(item_i.channel - 8'd1);

  always_comb begin
    pre_d     = pre_q;
    cnt_d     = cnt_q;
    en_d      = en_q;
    preload_d = preload_q;
    active_d  = active_q;
    if (push_i) begin
      if (item_i.init_now) begin
        for (int i = 0; i < NCH; i++) begin
          preload_d[i] = duty_lut[init_idx];
          active_d[i]  = duty_lut[init_idx];
        end
        pre_d = '0;
        cnt_d = '0;
        en_d  = 1'b1;
      end
      unique case (item_i.func)
        fcpwm_pkg::FUNC_TICK: begin
          if (en_d) begin
            if (pre_d >= PW'(PRESCALE_DIVIDE)) begin
              pre_d = '0;
              if (cnt_d >= CW'(PERIOD_TOP)) begin
                cnt_d    = '0;
                active_d = preload_d;
              end else begin
                cnt_d = cnt_d + CW'(1);
              end
            end else begin
              pre_d = pre_d + PW'(1);
            end
          end
        end
        fcpwm_pkg::FUNC_SET_DUTY: begin
          if (ch_ok) begin
            preload_d[ch_idx] = duty_lut[duty_idx];
          end
        end
        fcpwm_pkg::FUNC_START: en_d = 1'b1;
        fcpwm_pkg::FUNC_STOP:  en_d = 1'b0;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      lines[i] = en_d && (out_inv_q ^ (cnt_d < active_d[i]));
    end
  end

  assign res_o.pwm_lines   = lines;
  assign res_o.count_value = fcpwm_pkg::COUNT_OUT_W'(cnt_d);
  assign res_o.running     = en_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_inv_q      <= 1'b0;
      initial_duty_q <= '0;
      pre_q          <= '0;
      cnt_q          <= '0;
      en_q           <= 1'b0;
      for (int i = 0; i < NCH; i++) begin
        preload_q[i] <= '0;
        active_q[i]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fcpwm_pkg::REG_OUT_INV:      out_inv_q      <= cfg_wdata_i[0];
          fcpwm_pkg::REG_INITIAL_DUTY: initial_duty_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      pre_q     <= pre_d;
      cnt_q     <= cnt_d;
      en_q      <= en_d;
      preload_q <= preload_d;
      active_q  <= active_d;
    end
  end

  `FCPWM_ASSERT_IMP(a_pre_range, 1'b1, pre_q <= PW'(PRESCALE_DIVIDE))
  `FCPWM_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CW'(PERIOD_TOP))
  `FCPWM_ASSERT_NXT(a_stopped_hold,
    push_i && !en_q && !item_i.init_now && item_i.func == fcpwm_pkg::FUNC_TICK,
    $stable(cnt_q) && $stable(pre_q))

endmodule

// File: src/fcpwm_out_buf.sv
// Two-entry result buffer between the timer core and the result channel.
`include "four_channel_pwm_timer_unit_defines.svh"

module fcpwm_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  fcpwm_pkg::result_t res_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               ready_i,
  output fcpwm_pkg::result_t res_o
);

  logic               out_valid_q, skid_valid_q;
  fcpwm_pkg::result_t out_q, skid_q;
  logic               pop;

  assign pop     = out_valid_q && ready_i;
  assign full_o  = skid_valid_q;
  assign valid_o = out_valid_q;
  assign res_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q  <= skid_valid_q;
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      if (!out_valid_q || pop) begin
        out_q <= res_i;
      end else begin
        skid_q <= res_i;
      end
    end else if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  `FCPWM_ASSERT_IMP(a_skid_implies_out, skid_valid_q, out_valid_q)
  `FCPWM_ASSERT_NXT(a_empty_push, push_i && !out_valid_q, out_valid_q && !skid_valid_q)

endmodule

// File: src/four_channel_pwm_timer_unit.sv
// Top level of the four-channel edge-aligned PWM timer.
//
// Requests arrive on the s_axis channel: tuser carries the function code
// (tick, set duty, start, stop), tdata the channel, duty and init flag.
// Every accepted request yields exactly one result on m_axis: the four PWM
// line levels, the main counter and the running flag after that request.
// Configuration (output polarity, initial duty) is written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i; the user must write it only while the block is
// idle, which the block itself does not enforce. Requests are taken one per
// cycle while s_axis_tready is high; the state update and compare lanes are
// combinational and their result is registered in the result buffer.
// A two-entry result buffer lets a request be taken while one result waits;
// s_axis_tready drops only while both entries are occupied by a stalled
// receiver, and results leave in request order.
// Reset clears the counters and compares, stops the timer, sets both
// configuration registers to zero and empties the result buffer.
module four_channel_pwm_timer_unit #(
  parameter int PRESCALE_DIVIDE = fcpwm_pkg::PRESCALE_DIVIDE_DEF,
  parameter int PERIOD_TOP      = fcpwm_pkg::PERIOD_TOP_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fcpwm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fcpwm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [23:0]                      s_axis_tdata,  // channel, duty, init_now
  input  logic [1:0]                       s_axis_tuser,  // func
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [15:0]                      m_axis_tdata   // pwm_lines, count_value, running
);

  fcpwm_pkg::item_t   item;
  fcpwm_pkg::result_t core_res, buf_res;
  logic               push, full;

  assign s_axis_tready = !full;
  assign push          = s_axis_tvalid && !full;

  assign item.func     = fcpwm_pkg::func_e'(s_axis_tuser);
  assign item.channel  = s_axis_tdata[7:0];
  assign item.duty     = s_axis_tdata[15:8];
  assign item.init_now = s_axis_tdata[16];

  fcpwm_core #(
    .PRESCALE_DIVIDE (PRESCALE_DIVIDE),
    .PERIOD_TOP      (PERIOD_TOP)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .item_i      (item),
    .res_o       (core_res)
  );

  fcpwm_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (core_res),
    .full_o  (full),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (buf_res)
  );

  assign m_axis_tdata = {1'b0, buf_res.running, buf_res.count_value, buf_res.pwm_lines};

endmodule
